// ===== hw/rtl/lz77_pkg.sv =====
// Shared constants and types of the LZ77 stream decompressor.
package lz77_pkg;

   localparam int HISTORY_DEPTH = 4096;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int SIZE_W        = 24;
   localparam int DIST_W        = 12;
   localparam int COUNT_W       = 5;
   localparam int MIN_MATCH     = 3;

   localparam logic [2:0] HDR_TYPE_LZ77 = 3'd1;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_TYPE = 2'd1;
   localparam logic [1:0] ERR_BAD_REF  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_FLAG,
      PH_DATA,
      PH_TOKEN_LO,
      PH_COPY
   } phase_type;

endpackage

// ===== hw/rtl/lz77_if.sv =====
// Valid/ready channel interfaces for compressed input and decoded output.
interface lz77_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_req;

   modport source (output valid, in_byte, start_req, input ready);
   modport sink   (input valid, in_byte, start_req, output ready);
endinterface

interface lz77_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_done;
   logic [1:0] error_code;

   modport source (output valid, out_byte, run_last, stream_done, error_code, input ready);
   modport sink   (input valid, out_byte, run_last, stream_done, error_code, output ready);
endinterface

// ===== hw/rtl/lz77_hist_ram.sv =====
// Simple dual-port history RAM with registered read.
module lz77_hist_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/lz77_stream_decompressor.sv =====
// Top level of the LZ77 stream decompressor (12-bit distance, 4-bit length).
// Header, flag and literal bytes go at one per cycle when the output register is free.
// A back-reference issues the first history read as its token is taken, then gives
// one byte per cycle from the history RAM (up to 18) while the output register is free,
// with write-to-read forwarding for distance 0; stalls hold the copy.
// Synchronous reset clears the parser state; history content is undefined until written.
module lz77_stream_decompressor (
   input  logic             clock,
   input  logic             reset,
   lz77_req_if.sink         req_ch,
   lz77_rsp_if.source       rsp_ch
);

   localparam int AW = lz77_pkg::HIST_AW;
   localparam int SW = lz77_pkg::SIZE_W;
   localparam int CW = lz77_pkg::COUNT_W;

   lz77_pkg::phase_type phase_ff, phase_in;
   logic [1:0]    hdr_idx_ff, hdr_idx_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] bp_ff, bp_in;
   logic [7:0]    flag_ff, flag_in;
   logic [3:0]    bits_ff, bits_in;
   logic [7:0]    tok_hi_ff, tok_hi_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] src_ff, src_in;
   logic          fwd_ff, fwd_in;
   logic [7:0]    fwd_data_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff, rsp_done_ff;
   logic [1:0]    rsp_err_ff;

   logic          emit;
   logic [7:0]    emit_byte;
   logic          emit_last, emit_done;
   logic [1:0]    emit_err;

   logic          wr_en;
   logic [7:0]    wr_data;
   logic [AW-1:0] wr_addr;
   logic [7:0]    ram_q, copy_byte;

   logic          out_free, accept, start_now, copy_emit;
   lz77_pkg::phase_type eff_phase;
   logic [1:0]    eff_hdr_idx;
   logic [SW-1:0] eff_size, eff_bp, bp_inc, size_hdr;
   logic [7:0]    b;
   logic          done_put, type_bad, ref_bad;
   logic [lz77_pkg::DIST_W-1:0] ref_dist;
   logic [3:0]    bits_dec;
   logic [AW-1:0] src_new;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = out_free && (phase_ff != lz77_pkg::PH_COPY);
   assign accept      = req_ch.valid && req_ch.ready;
   assign start_now   = accept && req_ch.start_req;
   assign copy_emit   = (phase_ff == lz77_pkg::PH_COPY) && out_free;
   assign b           = req_ch.in_byte;

   assign eff_phase   = start_now ? lz77_pkg::PH_HEADER : phase_ff;
   assign eff_hdr_idx = start_now ? 2'd0 : hdr_idx_ff;
   assign eff_size    = start_now ? '0 : size_ff;
   assign eff_bp      = start_now ? '0 : bp_ff;
   assign bp_inc      = eff_bp + SW'(1);
   assign done_put    = bp_inc >= eff_size;
   assign type_bad    = b[6:4] != lz77_pkg::HDR_TYPE_LZ77;
   assign ref_dist    = {tok_hi_ff[3:0], b};
   assign ref_bad     = SW'(ref_dist) >= eff_bp;
   assign bits_dec    = bits_ff - 4'd1;
   assign src_new     = eff_bp[AW-1:0] - AW'(ref_dist) - AW'(1);
   assign copy_byte   = fwd_ff ? fwd_data_ff : ram_q;

   always_comb begin
      unique case (eff_hdr_idx)
         2'd1:    size_hdr = eff_size | SW'(b);
         2'd2:    size_hdr = eff_size | (SW'(b) << 8);
         2'd3:    size_hdr = eff_size | (SW'(b) << 16);
         default: size_hdr = eff_size;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (copy_emit) begin
         if (done_put) begin
            phase_in = lz77_pkg::PH_IDLE;
         end else if (cnt_ff == CW'(1)) begin
            phase_in = (bits_dec == 4'd0) ? lz77_pkg::PH_FLAG : lz77_pkg::PH_DATA;
         end
      end else if (accept) begin
         unique case (eff_phase)
            lz77_pkg::PH_IDLE: phase_in = lz77_pkg::PH_IDLE;
            lz77_pkg::PH_HEADER: begin
               if (eff_hdr_idx == 2'd0) begin
                  phase_in = type_bad ? lz77_pkg::PH_IDLE : lz77_pkg::PH_HEADER;
               end else if (eff_hdr_idx == 2'd3) begin
                  phase_in = (size_hdr == '0) ? lz77_pkg::PH_IDLE : lz77_pkg::PH_FLAG;
               end else begin
                  phase_in = lz77_pkg::PH_HEADER;
               end
            end
            lz77_pkg::PH_FLAG: phase_in = lz77_pkg::PH_DATA;
            lz77_pkg::PH_DATA: begin
               if (flag_ff[7]) begin
                  phase_in = lz77_pkg::PH_TOKEN_LO;
               end else if (done_put) begin
                  phase_in = lz77_pkg::PH_IDLE;
               end else begin
                  phase_in = (bits_dec == 4'd0) ? lz77_pkg::PH_FLAG : lz77_pkg::PH_DATA;
               end
            end
            lz77_pkg::PH_TOKEN_LO: phase_in = ref_bad ? lz77_pkg::PH_IDLE : lz77_pkg::PH_COPY;
            lz77_pkg::PH_COPY: phase_in = lz77_pkg::PH_COPY;
            default: phase_in = lz77_pkg::PH_IDLE;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      hdr_idx_in = hdr_idx_ff;
      size_in    = size_ff;
      bp_in      = bp_ff;
      flag_in    = flag_ff;
      bits_in    = bits_ff;
      tok_hi_in  = tok_hi_ff;
      cnt_in     = cnt_ff;
      src_in     = src_ff;
      emit       = 1'b0;
      emit_byte  = 8'd0;
      emit_last  = 1'b0;
      emit_done  = 1'b0;
      emit_err   = lz77_pkg::ERR_NONE;
      wr_en      = 1'b0;
      wr_data    = b;
      if (copy_emit) begin
         emit      = 1'b1;
         emit_byte = copy_byte;
         emit_done = done_put;
         emit_last = done_put || (cnt_ff == CW'(1));
         wr_en     = 1'b1;
         wr_data   = copy_byte;
         bp_in     = bp_inc;
         cnt_in    = cnt_ff - CW'(1);
         src_in    = src_ff + AW'(1);
         if (!done_put && cnt_ff == CW'(1)) begin
            flag_in = {flag_ff[6:0], 1'b0};
            bits_in = bits_dec;
         end
      end else if (accept) begin
         if (start_now) begin
            hdr_idx_in = 2'd0;
            size_in    = '0;
            bp_in      = '0;
            flag_in    = '0;
            bits_in    = '0;
            tok_hi_in  = '0;
         end
         unique case (eff_phase)
            lz77_pkg::PH_HEADER: begin
               if (eff_hdr_idx == 2'd0) begin
                  if (type_bad) begin
                     emit      = 1'b1;
                     emit_last = 1'b1;
                     emit_done = 1'b1;
                     emit_err  = lz77_pkg::ERR_BAD_TYPE;
                  end else begin
                     hdr_idx_in = 2'd1;
                  end
               end else begin
                  size_in    = size_hdr;
                  hdr_idx_in = eff_hdr_idx + 2'd1;
               end
            end
            lz77_pkg::PH_FLAG: begin
               flag_in = b;
               bits_in = 4'd8;
            end
            lz77_pkg::PH_DATA: begin
               if (flag_ff[7]) begin
                  tok_hi_in = b;
               end else begin
                  emit      = 1'b1;
                  emit_byte = b;
                  emit_last = 1'b1;
                  emit_done = done_put;
                  wr_en     = 1'b1;
                  bp_in     = bp_inc;
                  if (!done_put) begin
                     flag_in = {flag_ff[6:0], 1'b0};
                     bits_in = bits_dec;
                  end
               end
            end
            lz77_pkg::PH_TOKEN_LO: begin
               if (ref_bad) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  emit_done = 1'b1;
                  emit_err  = lz77_pkg::ERR_BAD_REF;
               end else begin
                  src_in = src_new;
                  cnt_in = CW'(tok_hi_ff[7:4]) + CW'(lz77_pkg::MIN_MATCH);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_addr      = bp_ff[AW-1:0];
   assign fwd_in       = wr_en && (wr_addr == src_in);
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ch.ready);

   lz77_hist_ram #(
      .DEPTH (lz77_pkg::HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (src_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lz77_pkg::PH_IDLE;
         hdr_idx_ff   <= '0;
         size_ff      <= '0;
         bp_ff        <= '0;
         flag_ff      <= '0;
         bits_ff      <= '0;
         tok_hi_ff    <= '0;
         cnt_ff       <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         size_ff      <= size_in;
         bp_ff        <= bp_in;
         flag_ff      <= flag_in;
         bits_ff      <= bits_in;
         tok_hi_ff    <= tok_hi_in;
         cnt_ff       <= cnt_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      fwd_data_ff <= wr_data;
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
         rsp_done_ff <= emit_done;
         rsp_err_ff  <= emit_err;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = rsp_byte_ff;
   assign rsp_ch.run_last    = rsp_last_ff;
   assign rsp_ch.stream_done = rsp_done_ff;
   assign rsp_ch.error_code  = rsp_err_ff;

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lz77_pkg::PH_COPY) |-> (cnt_ff != '0 && cnt_ff <= CW'(18)))
      else $error("copy active with bad remaining count");

   a_err_idle: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_err != lz77_pkg::ERR_NONE) |=> (phase_ff == lz77_pkg::PH_IDLE))
      else $error("stream not closed after error result");

   a_below_size: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lz77_pkg::PH_FLAG || phase_ff == lz77_pkg::PH_DATA ||
       phase_ff == lz77_pkg::PH_TOKEN_LO || phase_ff == lz77_pkg::PH_COPY)
      |-> (bp_ff < size_ff))
      else $error("decoding continued past decoded size");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result produced while output register occupied");

endmodule
